>>> src/ffsa_pkg.sv
// shared types and constants of the first-fit segment allocator
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int ADDR_BITS    = 32;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int ALIGN_W      = 16;
    localparam int SIZE_W       = 32;
    localparam logic [ADDR_BITS-1:0] HEAP_RESET = ADDR_BITS'(67108864);

    typedef struct packed {
        logic                 used;
        logic [ADDR_BITS-1:0] length;
        logic [ADDR_BITS-1:0] start;
    } seg_entry_t;

    localparam int ENTRY_W = $bits(seg_entry_t);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOMEM    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MOD,
        S_FIT,
        S_CP_RD,
        S_CP_WR,
        S_WR_REM,
        S_WR_USED,
        S_NX_RD,
        S_NX_CHK,
        S_PV_RD,
        S_PV_CHK,
        S_WR_MRG,
        S_DONE
    } fsm_state_t;

endpackage

>>> src/ffsa_ram.sv
// generic single-write, single-read ram with registered read data
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/ffsa_mod.sv
// iterative remainder unit: one dividend bit per cycle
module ffsa_mod (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]    dividend,
    input  logic [ffsa_pkg::ALIGN_W-1:0]      divisor,
    output logic                              done,
    output logic [ffsa_pkg::ALIGN_W-1:0]      rem
);

    localparam int STEP_W = $clog2(ffsa_pkg::ADDR_BITS);

    logic                           busy_reg;
    logic                           done_reg;
    logic [STEP_W-1:0]              step_reg;
    logic [ffsa_pkg::ADDR_BITS-1:0] div_reg;
    logic [ffsa_pkg::ALIGN_W:0]     r_reg;
    logic [ffsa_pkg::ALIGN_W:0]     r_shift;
    logic [ffsa_pkg::ALIGN_W:0]     r_next;

    always_comb
    begin
        r_shift = {r_reg[ffsa_pkg::ALIGN_W-1:0], div_reg[ffsa_pkg::ADDR_BITS-1]};
        if (r_shift >= {1'b0, divisor})
        begin
            r_next = r_shift - {1'b0, divisor};
        end
        else
        begin
            r_next = r_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ffsa_pkg::ADDR_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= dividend;
            r_reg   <= '0;
        end
        else if (busy_reg)
        begin
            div_reg <= {div_reg[ffsa_pkg::ADDR_BITS-2:0], 1'b0};
            r_reg   <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg[ffsa_pkg::ALIGN_W-1:0];

endmodule

>>> src/first_fit_segment_allocator.sv
// first-fit segment allocator with coalescing: sequencer over the segment table
//
// channel        dir  signals                      contents
// s_axis         in   tvalid tready tdata tuser    tuser: action; tdata: size, align, start
// m_axis         out  tvalid tready tdata tuser    tuser: status; tdata: segment, aligned
// heap_size      in   heap_size_we heap_size_wdata total heap bytes, reinitializes table
//
// allocate: passes used segments, tries each free segment through the remainder unit
// and moves the entries above it up by one on a split.
// free: scans for the segment, reads its neighbors and moves entries down on a merge.
// reset and a heap_size write take effect at once; no clearing pass.
// m_axis holds its result while stalled; s_axis is ready only between requests.
module first_fit_segment_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // request_size[31:0] alignment[47:32] block_start[79:48]
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // segment_start[31:0] aligned_start[63:32]
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        heap_size_we,
    input  logic [31:0] heap_size_wdata
);

    localparam int AW = ffsa_pkg::ADDR_BITS;
    localparam int IW = ffsa_pkg::IDX_W;
    localparam int CW = ffsa_pkg::CNT_W;
    localparam int LW = ffsa_pkg::ALIGN_W;

    ffsa_pkg::fsm_state_t state_reg, state_next;

    logic [AW-1:0]             heap_reg;
    logic                      fresh_reg;
    logic                      rd_sub_reg;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [CW-1:0]             dst_reg, dst_next;
    logic [1:0]                del_reg, del_next;
    logic                      cp_up_reg, cp_up_next;
    ffsa_pkg::action_t         act_reg;
    logic [ffsa_pkg::SIZE_W-1:0] size_reg;
    logic [LW-1:0]             al_reg;
    logic [AW-1:0]             blk_reg;
    ffsa_pkg::seg_entry_t      cur_reg, cur_next;
    logic [LW-1:0]             pad_reg, pad_next;
    logic [AW:0]               need_reg, need_next;
    logic                      nfree_reg, nfree_next;
    logic [AW-1:0]             nlen_reg, nlen_next;
    logic                      pfree_reg, pfree_next;
    logic [AW-1:0]             plen_reg, plen_next;
    logic [AW-1:0]             pstart_reg, pstart_next;
    ffsa_pkg::status_t         status_reg, status_next;
    logic [AW-1:0]             sstart_reg, sstart_next;
    logic [AW-1:0]             astart_reg, astart_next;
    logic                      mvalid_reg;
    logic [1:0]                mstatus_reg;
    logic [AW-1:0]             mseg_reg;
    logic [AW-1:0]             maln_reg;

    logic                      in_xfer;
    logic                      load_out;
    logic                      ram_we;
    logic [IW-1:0]             ram_waddr;
    ffsa_pkg::seg_entry_t      ram_wdata;
    logic [IW-1:0]             ram_raddr;
    logic                      ram_re;
    logic [ffsa_pkg::ENTRY_W-1:0] ram_rdata;
    ffsa_pkg::seg_entry_t      rd_entry;
    logic                      mod_start;
    logic                      mod_done;
    logic [LW-1:0]             mod_rem;
    logic [LW-1:0]             pad_calc;
    logic [AW:0]               need_calc;
    logic [AW-1:0]             mlen;

    ffsa_ram #(
        .WIDTH (ffsa_pkg::ENTRY_W),
        .DEPTH (ffsa_pkg::MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffsa_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (cur_next.start),
        .divisor  (al_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // entry 0 reads as the initial whole-heap segment until first written
    always_comb
    begin
        if (rd_sub_reg)
        begin
            rd_entry.used   = 1'b0;
            rd_entry.length = heap_reg;
            rd_entry.start  = '0;
        end
        else
        begin
            rd_entry = ffsa_pkg::seg_entry_t'(ram_rdata);
        end
    end

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign pad_calc  = (mod_rem == '0) ? '0 : al_reg - mod_rem;
    assign need_calc = {1'b0, size_reg} + {{(AW + 1 - LW){1'b0}}, pad_calc};
    assign mlen      = cur_reg.length + (nfree_reg ? nlen_reg : '0);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        dst_next      = dst_reg;
        del_next      = del_reg;
        cp_up_next    = cp_up_reg;
        cur_next      = cur_reg;
        pad_next      = pad_reg;
        need_next     = need_reg;
        nfree_next    = nfree_reg;
        nlen_next     = nlen_reg;
        pfree_next    = pfree_reg;
        plen_next     = plen_reg;
        pstart_next   = pstart_reg;
        status_next   = status_reg;
        sstart_next   = sstart_reg;
        astart_next   = astart_reg;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg[IW-1:0];
        ram_wdata     = cur_reg;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg[IW-1:0];
        mod_start     = 1'b0;

        case (state_reg)
            ffsa_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    idx_next    = '0;
                    sstart_next = '0;
                    astart_next = '0;
                    status_next = s_axis_tuser ? ffsa_pkg::ST_NOTFOUND
                                               : ffsa_pkg::ST_NOMEM;
                    state_next  = ffsa_pkg::S_SCAN_RD;
                end
            end
            ffsa_pkg::S_SCAN_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = ffsa_pkg::S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ffsa_pkg::S_SCAN_CHK;
                end
            end
            ffsa_pkg::S_SCAN_CHK:
            begin
                cur_next = rd_entry;
                if (act_reg == ffsa_pkg::ACT_ALLOC)
                begin
                    if (rd_entry.used)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ffsa_pkg::S_SCAN_RD;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ffsa_pkg::S_MOD;
                    end
                end
                else if (rd_entry.used && rd_entry.start == blk_reg)
                begin
                    nfree_next = 1'b0;
                    pfree_next = 1'b0;
                    if (idx_reg + 1'b1 < cnt_reg)
                    begin
                        state_next = ffsa_pkg::S_NX_RD;
                    end
                    else if (idx_reg != '0)
                    begin
                        state_next = ffsa_pkg::S_PV_RD;
                    end
                    else
                    begin
                        state_next = ffsa_pkg::S_WR_MRG;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ffsa_pkg::S_SCAN_RD;
                end
            end
            ffsa_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ffsa_pkg::S_FIT;
                end
            end
            ffsa_pkg::S_FIT:
            begin
                pad_next  = pad_calc;
                need_next = need_calc;
                if ({1'b0, cur_reg.length} < need_calc)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ffsa_pkg::S_SCAN_RD;
                end
                else if ({1'b0, cur_reg.length} != need_calc)
                begin
                    if (cnt_reg >= CW'(ffsa_pkg::MAX_SEGMENTS))
                    begin
                        status_next = ffsa_pkg::ST_FULL;
                        state_next  = ffsa_pkg::S_DONE;
                    end
                    else
                    begin
                        cp_up_next = 1'b1;
                        dst_next   = cnt_reg;
                        state_next = ffsa_pkg::S_CP_RD;
                    end
                end
                else
                begin
                    state_next = ffsa_pkg::S_WR_USED;
                end
            end
            ffsa_pkg::S_CP_RD:
            begin
                if (cp_up_reg)
                begin
                    if (dst_reg == idx_reg + 1'b1)
                    begin
                        state_next = ffsa_pkg::S_WR_REM;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = IW'(dst_reg - 1'b1);
                        state_next = ffsa_pkg::S_CP_WR;
                    end
                end
                else if (del_reg == '0 || dst_reg + CW'(del_reg) >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - CW'(del_reg);
                    state_next = ffsa_pkg::S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = IW'(dst_reg + CW'(del_reg));
                    state_next = ffsa_pkg::S_CP_WR;
                end
            end
            ffsa_pkg::S_CP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = dst_reg[IW-1:0];
                ram_wdata  = rd_entry;
                dst_next   = cp_up_reg ? dst_reg - 1'b1 : dst_reg + 1'b1;
                state_next = ffsa_pkg::S_CP_RD;
            end
            ffsa_pkg::S_WR_REM:
            begin
                ram_we           = 1'b1;
                ram_waddr        = IW'(idx_reg + 1'b1);
                ram_wdata.used   = 1'b0;
                ram_wdata.start  = cur_reg.start + need_reg[AW-1:0];
                ram_wdata.length = cur_reg.length - need_reg[AW-1:0];
                cnt_next         = cnt_reg + 1'b1;
                state_next       = ffsa_pkg::S_WR_USED;
            end
            ffsa_pkg::S_WR_USED:
            begin
                ram_we           = 1'b1;
                ram_wdata.used   = 1'b1;
                ram_wdata.start  = cur_reg.start;
                ram_wdata.length = need_reg[AW-1:0];
                status_next      = ffsa_pkg::ST_OK;
                sstart_next      = cur_reg.start;
                astart_next      = cur_reg.start + {{(AW - LW){1'b0}}, pad_reg};
                state_next       = ffsa_pkg::S_DONE;
            end
            ffsa_pkg::S_NX_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = IW'(idx_reg + 1'b1);
                state_next = ffsa_pkg::S_NX_CHK;
            end
            ffsa_pkg::S_NX_CHK:
            begin
                nfree_next = !rd_entry.used;
                nlen_next  = rd_entry.length;
                state_next = (idx_reg != '0) ? ffsa_pkg::S_PV_RD : ffsa_pkg::S_WR_MRG;
            end
            ffsa_pkg::S_PV_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = IW'(idx_reg - 1'b1);
                state_next = ffsa_pkg::S_PV_CHK;
            end
            ffsa_pkg::S_PV_CHK:
            begin
                pfree_next  = !rd_entry.used;
                plen_next   = rd_entry.length;
                pstart_next = rd_entry.start;
                state_next  = ffsa_pkg::S_WR_MRG;
            end
            ffsa_pkg::S_WR_MRG:
            begin
                ram_we         = 1'b1;
                ram_wdata.used = 1'b0;
                cp_up_next     = 1'b0;
                status_next    = ffsa_pkg::ST_OK;
                sstart_next    = blk_reg;
                if (pfree_reg)
                begin
                    ram_waddr        = IW'(idx_reg - 1'b1);
                    ram_wdata.start  = pstart_reg;
                    ram_wdata.length = plen_reg + mlen;
                    dst_next         = idx_reg;
                    del_next         = nfree_reg ? 2'd2 : 2'd1;
                end
                else
                begin
                    ram_wdata.start  = cur_reg.start;
                    ram_wdata.length = mlen;
                    dst_next         = idx_reg + 1'b1;
                    del_next         = nfree_reg ? 2'd1 : 2'd0;
                end
                state_next = ffsa_pkg::S_CP_RD;
            end
            ffsa_pkg::S_DONE:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ffsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ffsa_pkg::S_IDLE;
            heap_reg   <= ffsa_pkg::HEAP_RESET;
            fresh_reg  <= 1'b1;
            rd_sub_reg <= 1'b0;
            cnt_reg    <= CW'(1);
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_sub_reg <= ram_re && fresh_reg && (ram_raddr == '0);
            if (heap_size_we)
            begin
                heap_reg  <= heap_size_wdata;
                fresh_reg <= 1'b1;
                cnt_reg   <= CW'(1);
            end
            else
            begin
                cnt_reg <= cnt_next;
                if (ram_we && ram_waddr == '0)
                begin
                    fresh_reg <= 1'b0;
                end
            end
            if (load_out)
            begin
                mvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg  <= ffsa_pkg::action_t'(s_axis_tuser);
            size_reg <= s_axis_tdata[31:0];
            al_reg   <= (s_axis_tdata[47:32] == '0) ? LW'(1) : s_axis_tdata[47:32];
            blk_reg  <= s_axis_tdata[79:48];
        end
        idx_reg    <= idx_next;
        dst_reg    <= dst_next;
        del_reg    <= del_next;
        cp_up_reg  <= cp_up_next;
        cur_reg    <= cur_next;
        pad_reg    <= pad_next;
        need_reg   <= need_next;
        nfree_reg  <= nfree_next;
        nlen_reg   <= nlen_next;
        pfree_reg  <= pfree_next;
        plen_reg   <= plen_next;
        pstart_reg <= pstart_next;
        status_reg <= status_next;
        sstart_reg <= sstart_next;
        astart_reg <= astart_next;
        if (load_out)
        begin
            mstatus_reg <= status_reg;
            mseg_reg    <= sstart_reg;
            maln_reg    <= astart_reg;
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tuser  = mstatus_reg;
    assign m_axis_tdata  = {maln_reg, mseg_reg};

    // table never empty and never beyond capacity
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 && cnt_reg <= CW'(ffsa_pkg::MAX_SEGMENTS))
        else $error("segment count out of range");

    // scan pointer never runs past the table
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffsa_pkg::S_SCAN_CHK |-> idx_reg < cnt_reg)
        else $error("scan index beyond segment count");

    // an accepted request blocks further transfers until finished
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input accepted while busy");

    // every error result carries zero addresses
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ffsa_pkg::ST_OK |-> m_axis_tdata == '0)
        else $error("error result with nonzero address");

endmodule
